/* rtl/tma_pkg.sv */
// Shared types and codes for the trimmed moving average block.
package tma_pkg;

	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int LEN_RESET       = 4;

	// Configuration register indexes
	localparam logic CFG_LENGTH = 1'b0;
	localparam logic CFG_TRIM   = 1'b1;

	// Request opcodes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear;
		logic take;
		logic write;
		logic rd_prev;
		logic rd_oldest;
		logic scan;
		logic trim;
		logic div_mean;
		logic div_trend;
		logic cap_mean;
		logic cap_trend;
		logic load_out;
	} tma_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scan_last;
		logic div_done;
		logic out_free;
	} tma_sts_t;

endpackage

/* rtl/tma_div.sv */
// Bit-serial restoring divider, signed dividend given as sign and magnitude.
module tma_div #(
	parameter int DW = 30,
	parameter int VW = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               neg,
	input  logic [DW-1:0]      mag,
	input  logic [VW-1:0]      divisor,
	output logic               done,
	output logic signed [DW:0] quo
);

	localparam int CNTW = $clog2(DW + 1);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   q_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   d_q;
	logic            neg_q;
	logic            done_q;
	logic [VW:0]     trial;
	logic            fits;
	logic [VW:0]     diff;

	// One quotient bit per cycle
	assign trial = {rem_q, q_q[DW-1]};
	assign fits  = trial >= {1'b0, d_q};
	assign diff  = trial - {1'b0, d_q};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift the partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= mag;
			rem_q <= '0;
			d_q   <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			q_q   <= {q_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

endmodule

/* rtl/tma_dp.sv */
// Datapath: sample window, running sum, scan, divider and result register.
module tma_dp #(
	parameter int WINDOW_MAX  = tma_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF,
	parameter int CW          = $clog2(WINDOW_MAX + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tma_pkg::tma_cmd_t             cmd,
	output tma_pkg::tma_sts_t             sts,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [CW-1:0]                 cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS+7:0] mean_q8,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic signed [SAMPLE_BITS:0]   step_difference,
	output logic signed [SAMPLE_BITS+8:0] trend_q8,
	output logic                          cycle_done,
	output logic [CW-1:0]                 sample_count
);

	localparam int S  = SAMPLE_BITS;
	localparam int AW = $clog2(WINDOW_MAX);
	localparam int SW = S + AW;
	localparam int DW = SW + 8;

	logic [CW-1:0]        wl_q;
	logic                 trim_q;
	logic [CW-1:0]        len;
	logic signed [S-1:0]  sample_q;
	logic [AW-1:0]        wp_q;
	logic [AW-1:0]        wp_old_q;
	logic [CW-1:0]        fill_q;
	logic signed [SW-1:0] sum_q;
	logic signed [S-1:0]  mem_q [WINDOW_MAX];
	logic signed [S-1:0]  rd_q;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        prev_idx;
	logic [AW-1:0]        oldest_idx;
	logic [AW-1:0]        idx_q;
	logic                 prev_pend_q;
	logic                 old_pend_q;
	logic                 scan_pend_q;
	logic                 first_pend_q;
	logic signed [S-1:0]  prev_q;
	logic signed [S-1:0]  oldest_q;
	logic signed [S-1:0]  mn_q;
	logic signed [S-1:0]  mx_q;
	logic signed [SW-1:0] tsum_q;
	logic [CW-1:0]        tn_q;
	logic signed [SW:0]   tsum_c;
	logic [CW-1:0]        tn_c;
	logic signed [S-1:0]  old_val;
	logic                 len_wr;
	logic                 wrap_n;
	logic [AW-1:0]        wp_inc;
	logic signed [S:0]    delta;
	logic [SW-1:0]        tsum_abs;
	logic [S:0]           delta_abs;
	logic                 div_start;
	logic                 div_neg;
	logic [DW-1:0]        div_mag;
	logic [CW-1:0]        div_den;
	logic                 div_done;
	logic signed [DW:0]   div_quo;
	logic                 two_plus;
	logic signed [S+7:0]  mean_q;
	logic signed [S:0]    diff_q;
	logic signed [S+8:0]  trend_q;
	logic                 out_valid_q;

	// Clamp the window length into range
	always_comb begin
		if (wl_q == '0)
			len = CW'(1);
		else if (wl_q > CW'(WINDOW_MAX))
			len = CW'(WINDOW_MAX);
		else
			len = wl_q;
	end

	assign len_wr   = cfg_valid && (cfg_index == tma_pkg::CFG_LENGTH);
	assign old_val  = (fill_q < len) ? '0 : rd_q;
	assign wp_inc   = wp_q + 1'b1;
	assign wrap_n   = (CW'(wp_q) + 1'b1) == len;
	assign two_plus = fill_q >= CW'(2);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= CW'(tma_pkg::LEN_RESET);
			trim_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == tma_pkg::CFG_LENGTH)
				wl_q <= cfg_data;
			else
				trim_q <= cfg_data[0];
		end
	end

	// Window control: write position, fill count, running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			wp_old_q <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
		end else if (cmd.clear || len_wr) begin
			wp_q   <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.write) begin
			wp_old_q <= wp_q;
			wp_q     <= wrap_n ? '0 : wp_inc;
			if (fill_q < len)
				fill_q <= fill_q + 1'b1;
			sum_q <= sum_q - SW'(old_val) + SW'(sample_q);
		end
	end

	// Hold the sample under work
	always_ff @(posedge clk) begin
		if (cmd.take)
			sample_q <= sample;
	end

	// Pick the read address
	assign prev_idx   = (wp_old_q == '0) ? AW'(len - 1'b1) : wp_old_q - 1'b1;
	assign oldest_idx = (fill_q >= len) ? wp_q : '0;

	always_comb begin
		if (cmd.rd_prev)
			rd_addr = prev_idx;
		else if (cmd.rd_oldest)
			rd_addr = oldest_idx;
		else if (cmd.scan)
			rd_addr = idx_q;
		else
			rd_addr = wp_q;
	end

	// Sample memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.write)
			mem_q[wp_q] <= sample_q;
		rd_q <= mem_q[rd_addr];
	end

	// Track what the last read fetched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pend_q  <= 1'b0;
			old_pend_q   <= 1'b0;
			scan_pend_q  <= 1'b0;
			first_pend_q <= 1'b0;
			idx_q        <= '0;
		end else begin
			prev_pend_q  <= cmd.rd_prev;
			old_pend_q   <= cmd.rd_oldest;
			scan_pend_q  <= cmd.scan;
			first_pend_q <= cmd.scan && (idx_q == '0);
			if (cmd.rd_oldest)
				idx_q <= '0;
			else if (cmd.scan)
				idx_q <= idx_q + 1'b1;
		end
	end

	assign sts.scan_last = CW'(idx_q) == (fill_q - 1'b1);

	// Capture neighbours and fold the min/max scan
	always_ff @(posedge clk) begin
		if (prev_pend_q)
			prev_q <= rd_q;
		if (old_pend_q)
			oldest_q <= rd_q;
		if (scan_pend_q) begin
			if (first_pend_q || rd_q < mn_q)
				mn_q <= rd_q;
			if (first_pend_q || rd_q > mx_q)
				mx_q <= rd_q;
		end
	end

	// With trim set, drop one minimum and one maximum while more than one sample remains
	always_comb begin
		tsum_c = {sum_q[SW-1], sum_q};
		tn_c   = fill_q;
		if (trim_q && tn_c > CW'(1)) begin
			tsum_c = tsum_c - (SW+1)'(mn_q);
			tn_c   = tn_c - 1'b1;
		end
		if (trim_q && tn_c > CW'(1)) begin
			tsum_c = tsum_c - (SW+1)'(mx_q);
			tn_c   = tn_c - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.trim) begin
			tsum_q <= tsum_c[SW-1:0];
			tn_q   <= tn_c;
		end
	end

	// Divider operands
	assign delta     = (S+1)'(sample_q) - (S+1)'(oldest_q);
	assign tsum_abs  = tsum_q[SW-1] ? SW'(-tsum_q) : SW'(tsum_q);
	assign delta_abs = delta[S] ? (S+1)'(-delta) : (S+1)'(delta);
	assign div_start = cmd.div_mean || cmd.div_trend;

	always_comb begin
		if (cmd.div_trend) begin
			div_neg = delta[S];
			div_mag = DW'({delta_abs, 8'b0});
			div_den = len - 1'b1;
		end else begin
			div_neg = tsum_q[SW-1];
			div_mag = {tsum_abs, 8'b0};
			div_den = tn_q;
		end
	end

	tma_div #(
		.DW(DW),
		.VW(CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.neg    (div_neg),
		.mag    (div_mag),
		.divisor(div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign sts.div_done = div_done;

	// Capture the quotients and the step difference
	always_ff @(posedge clk) begin
		if (cmd.cap_mean)
			mean_q <= div_quo[S+7:0];
		if (cmd.cap_trend) begin
			trend_q <= two_plus ? div_quo[S+8:0] : '0;
			diff_q  <= two_plus ? (S+1)'(sample_q) - (S+1)'(prev_q) : '0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mean_q8         <= mean_q;
			window_min      <= mn_q;
			window_max      <= mx_q;
			step_difference <= diff_q;
			trend_q8        <= trend_q;
			cycle_done      <= (wp_q == '0);
			sample_count    <= fill_q;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;

endmodule

/* rtl/tma_ctrl.sv */
// Controller: sequences each request through the datapath.
module tma_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	output logic              in_ready,
	input  tma_pkg::tma_sts_t sts,
	output tma_pkg::tma_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_WR    = 4'd1;
	localparam logic [3:0] ST_RPREV = 4'd2;
	localparam logic [3:0] ST_ROLD  = 4'd3;
	localparam logic [3:0] ST_SCAN  = 4'd4;
	localparam logic [3:0] ST_SEND  = 4'd5;
	localparam logic [3:0] ST_TRIM  = 4'd6;
	localparam logic [3:0] ST_DMS   = 4'd7;
	localparam logic [3:0] ST_DMW   = 4'd8;
	localparam logic [3:0] ST_DTS   = 4'd9;
	localparam logic [3:0] ST_DTW   = 4'd10;
	localparam logic [3:0] ST_DONE  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_n;

	// Next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == tma_pkg::OP_CLEAR) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.take = 1'b1;
						state_n  = ST_WR;
					end
				end
			end
			ST_WR: begin
				cmd.write = 1'b1;
				state_n   = ST_RPREV;
			end
			ST_RPREV: begin
				cmd.rd_prev = 1'b1;
				state_n     = ST_ROLD;
			end
			ST_ROLD: begin
				cmd.rd_oldest = 1'b1;
				state_n       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last)
					state_n = ST_SEND;
			end
			ST_SEND: begin
				state_n = ST_TRIM;
			end
			ST_TRIM: begin
				cmd.trim = 1'b1;
				state_n  = ST_DMS;
			end
			ST_DMS: begin
				cmd.div_mean = 1'b1;
				state_n      = ST_DMW;
			end
			ST_DMW: begin
				if (sts.div_done) begin
					cmd.cap_mean = 1'b1;
					state_n      = ST_DTS;
				end
			end
			ST_DTS: begin
				cmd.div_trend = 1'b1;
				state_n       = ST_DTW;
			end
			ST_DTW: begin
				if (sts.div_done) begin
					cmd.cap_trend = 1'b1;
					state_n       = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end

endmodule

/* rtl/trimmed_moving_average.sv */
// Top level of the trimmed moving average block.
//
//  channel  signals                          direction
//  in       in_valid/in_ready, opcode, sample   request in
//  out      out_valid/out_ready, seven fields   result out
//  cfg      cfg_valid/cfg_ready, index, data    register write in
//
// An add runs a one-read-port scan over the stored samples, then two
// bit-serial divisions on one shared divider. A clear empties the window
// from the idle state and gives no result. Reset leaves the window empty
// and the length at 4; no clearing pass is needed. A finished result waits
// in the output register while the next request is taken; a stalled output
// holds the block only at its final step.
module trimmed_moving_average #(
	parameter int WINDOW_MAX  = tma_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF,
	parameter int CW          = $clog2(WINDOW_MAX + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS+7:0] mean_q8,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic signed [SAMPLE_BITS:0]   step_difference,
	output logic signed [SAMPLE_BITS+8:0] trend_q8,
	output logic                          cycle_done,
	output logic [CW-1:0]                 sample_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [CW-1:0]                 cfg_data
);

	tma_pkg::tma_cmd_t cmd;
	tma_pkg::tma_sts_t sts;

	assign cfg_ready = 1'b1;

	tma_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.opcode  (opcode),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tma_dp #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS),
		.CW         (CW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample         (sample),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.mean_q8        (mean_q8),
		.window_min     (window_min),
		.window_max     (window_max),
		.step_difference(step_difference),
		.trend_q8       (trend_q8),
		.cycle_done     (cycle_done),
		.sample_count   (sample_count)
	);

`ifndef SYNTHESIS
	// An accepted add keeps the block busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == tma_pkg::OP_ADD) |=> !in_ready)
		else $error("add request not followed by busy");

	// A result always reports at least one held sample
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_count != '0)
		else $error("result with empty window");

	// Difference and trend are zero with fewer than two samples
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sample_count < CW'(2)) |-> (step_difference == '0 && trend_q8 == '0))
		else $error("difference or trend set with one sample");

	// Scanning never overlaps with taking a request
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !in_ready)
		else $error("scan while ready");
`endif

endmodule

/* bench/tb.sv */
// Self-checking bench for the trimmed moving average block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [23:0] mean;
		logic signed [15:0] mn;
		logic signed [15:0] mx;
		logic signed [16:0] diff;
		logic signed [24:0] trend;
		logic               cyc;
		logic [6:0]         cnt;
	} avg_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid, in_ready, opcode;
	logic signed [15:0] sample;
	logic               out_valid, out_ready;
	logic signed [23:0] mean_q8;
	logic signed [15:0] window_min, window_max;
	logic signed [16:0] step_difference;
	logic signed [24:0] trend_q8;
	logic               cycle_done;
	logic [6:0]         sample_count;
	logic               cfg_valid, cfg_ready, cfg_index;
	logic [6:0]         cfg_data;

	// Mirror of the block state
	longint      win_store [64];
	int          wr_pos, fill, len_reg;
	longint      acc_sum;
	logic        trim_reg;
	avg_result_t pending_results[$];
	int          errors = 0;
	bit          hold_long = 0;
	bit          rx_busy_free = 0;

	always #5 clk = ~clk;

	trimmed_moving_average dut (.*);

	function automatic int active_len();
		if (len_reg == 0) return 1;
		if (len_reg > 64) return 64;
		return len_reg;
	endfunction

	function automatic void empty_window();
		foreach (win_store[i]) win_store[i] = 0;
		wr_pos = 0;
		fill = 0;
		acc_sum = 0;
	endfunction

	// Work out the result of one add and queue it
	function automatic void predict_add(logic signed [15:0] s);
		int          len, n;
		longint      v, mn, mx, sum, newest, oldest;
		avg_result_t r;
		len = active_len();
		v = longint'(s);
		if (wr_pos >= len) wr_pos = 0;
		if (fill < len) fill++;
		acc_sum = acc_sum - win_store[wr_pos] + v;
		win_store[wr_pos] = v;
		wr_pos++;
		if (wr_pos >= len) wr_pos = 0;
		r.cyc = (wr_pos == 0);
		mn = win_store[0];
		mx = win_store[0];
		for (int i = 1; i < fill; i++) begin
			if (win_store[i] < mn) mn = win_store[i];
			if (win_store[i] > mx) mx = win_store[i];
		end
		sum = acc_sum;
		n = fill;
		if (trim_reg) begin
			if (n > 1) begin sum -= mn; n--; end
			if (n > 1) begin sum -= mx; n--; end
		end
		r.mean = 24'((sum * 256) / n);
		r.mn = 16'(mn);
		r.mx = 16'(mx);
		r.diff = '0;
		r.trend = '0;
		if (fill >= 2) begin
			newest = win_store[(wr_pos + len - 1) % len];
			oldest = (fill >= len) ? win_store[wr_pos] : win_store[0];
			r.diff = 17'(newest - win_store[(wr_pos + len - 2) % len]);
			r.trend = 25'(((newest - oldest) * 256) / (len - 1));
		end
		r.cnt = 7'(fill);
		pending_results.push_back(r);
	endfunction

	// Track accepted requests and register writes
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (opcode == tma_pkg::OP_CLEAR) empty_window();
			else predict_add(sample);
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == tma_pkg::CFG_LENGTH) begin
				len_reg = int'(cfg_data);
				empty_window();
			end else begin
				trim_reg = cfg_data[0];
			end
		end
	end

	function automatic void check_field(string name, longint e, longint a);
		if (e != a) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
		end
	endfunction

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		avg_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got mean %0d",
					$time, mean_q8);
			end else begin
				e = pending_results.pop_front();
				check_field("mean_q8", e.mean, mean_q8);
				check_field("window_min", e.mn, window_min);
				check_field("window_max", e.mx, window_max);
				check_field("step_difference", e.diff, step_difference);
				check_field("trend_q8", e.trend, trend_q8);
				check_field("cycle_done", e.cyc, cycle_done);
				check_field("sample_count", e.cnt, sample_count);
			end
		end
	end

	// Result side: random stalls, stall-free stretches, one long hold-off
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = rx_busy_free ? 0 : $urandom_range(0, 9);
			if (hold_long) begin
				stall = 600;
				hold_long = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_request(logic op, logic signed [15:0] s);
		int gap;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		sample <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic add_sample(logic signed [15:0] s);
		send_request(tma_pkg::OP_ADD, s);
	endtask

	// Drop valid and wait until every result is in
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [6:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 15)) - 8);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic test_reset_window();
		add_sample(16'sd100);
		add_sample(-16'sd50);
		add_sample(16'sd7);
		add_sample(16'sd1);
		add_sample(16'sd3);
	endtask

	task automatic test_extremes();
		write_reg(tma_pkg::CFG_LENGTH, 7'd1);
		add_sample(16'sh7fff);
		add_sample(16'sh8000);
		write_reg(tma_pkg::CFG_TRIM, 7'd1);
		write_reg(tma_pkg::CFG_LENGTH, 7'd0);
		add_sample(-16'sd1);
		add_sample(16'sd5);
		write_reg(tma_pkg::CFG_LENGTH, 7'd127);
		add_sample(16'sh8000);
		add_sample(16'sh7fff);
		add_sample(16'sh7fff);
		send_request(tma_pkg::OP_CLEAR, 16'sh7fff);
		add_sample(16'sd0);
		add_sample(-16'sd1);
		write_reg(tma_pkg::CFG_LENGTH, 7'd2);
		add_sample(16'sh8000);
		add_sample(16'sh7fff);
		add_sample(16'sh8000);
		write_reg(tma_pkg::CFG_TRIM, 7'd126);
		add_sample(16'sd9);
		add_sample(16'sh7fff);
		write_reg(tma_pkg::CFG_LENGTH, 7'd64);
		add_sample(16'sh8000);
		add_sample(16'sh7fff);
	endtask

	// Random phases over lengths and trim settings
	task automatic test_random_phases();
		int lens[6] = '{1, 2, 3, 5, 8, 64};
		int count;
		for (int ph = 0; ph < 16; ph++) begin
			if (ph % 4 == 0)
				write_reg(tma_pkg::CFG_LENGTH, 7'($urandom_range(0, 127)));
			else
				write_reg(tma_pkg::CFG_LENGTH,
					7'(lens[$urandom_range(0, 4)] + int'($urandom_range(0, 4))));
			if (ph == 7 || ph == 13) write_reg(tma_pkg::CFG_LENGTH, 7'd64);
			write_reg(tma_pkg::CFG_TRIM, 7'($urandom()));
			rx_busy_free = (ph % 5 == 2);
			count = (active_len() >= 32) ? 44 : 54;
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_request(tma_pkg::OP_CLEAR, 16'($urandom()));
				else
					add_sample(rand_sample());
			end
		end
		rx_busy_free = 0;
	endtask

	task automatic test_output_backpressure();
		write_reg(tma_pkg::CFG_LENGTH, 7'd6);
		write_reg(tma_pkg::CFG_TRIM, 7'd1);
		hold_long = 1;
		for (int i = 0; i < 8; i++) add_sample(rand_sample());
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= tma_pkg::OP_ADD;
		sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= tma_pkg::CFG_LENGTH;
		cfg_data <= '0;
		len_reg = tma_pkg::LEN_RESET;
		trim_reg = 1'b0;
		empty_window();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_extremes();
		test_random_phases();
		test_output_backpressure();
		drain();
		if (errors == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
